// ===== src/bsp_pkg.sv =====
// Shared types and constants for the bounded stack with palindrome check.
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_STATUS = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CMP,
        S_RESP
    } t_state;

endpackage

// ===== src/bsp_if.sv =====
// Request and response channel interfaces for the stack.
`timescale 1ns / 1ps

interface bsp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           req_type;
    logic signed [bsp_pkg::VALUE_W-1:0]   push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface bsp_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic signed [bsp_pkg::VALUE_W-1:0]   popped_value;
    logic                                 symmetric;
    logic [bsp_pkg::COUNT_W-1:0]          entry_count;
    logic                                 is_full;
    logic                                 is_empty;

    modport source (output valid, output status, output popped_value, output symmetric,
                    output entry_count, output is_full, output is_empty, input ready);
    modport sink   (input valid, input status, input popped_value, input symmetric,
                    input entry_count, input is_full, input is_empty, output ready);
endinterface

// ===== src/bsp_mem.sv =====
// Stack storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module bsp_mem #(
    parameter int DEPTH = bsp_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic [bsp_pkg::VALUE_W-1:0]        i_wdata,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr_a,
    input  logic [AW-1:0]                      i_raddr_b,
    output logic [bsp_pkg::VALUE_W-1:0]        o_rdata_a,
    output logic [bsp_pkg::VALUE_W-1:0]        o_rdata_b
);

    logic [bsp_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [bsp_pkg::VALUE_W-1:0] r_rdata_a;
    logic [bsp_pkg::VALUE_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/bounded_stack_with_palindrome_check.sv =====
// Top level: bounded LIFO stack with a sequenced palindrome check.
//
//  Channel  Dir  Handshake        Payload
//  i_req    in   valid / ready    req_type, push_value
//  o_rsp    out  valid / ready    status, popped_value, symmetric,
//                                 entry_count, is_full, is_empty
//
// Push, pop, status and a check on an empty stack go straight to S_RESP; the
// result is loaded into the output register from S_RESP.
// Palindrome check: pairs are compared from the ends inward (at most count/2
// pairs), stopping at the first pair that differs; one shared comparator
// works one pair at a time over the two read ports, S_CHK_RD then S_CHK_CMP.
// The next item is taken the cycle after the result is loaded; a loaded
// result may wait on o_rsp.ready while the next item runs. If the output
// register is still full when a result is ready, the sequencer waits.
// Synchronous active-low reset empties the stack; no clearing pass.
`timescale 1ns / 1ps

module bounded_stack_with_palindrome_check #(
    parameter int DEPTH = bsp_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsp_req_if.sink       i_req,
    bsp_rsp_if.source     o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bsp_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_lo, r_hi;
    bsp_pkg::t_status r_res_status;
    logic             r_res_pal;
    logic             r_res_pop;

    logic                         r_out_valid;
    bsp_pkg::t_status             r_out_status;
    logic [bsp_pkg::VALUE_W-1:0]  r_out_popped;
    logic                         r_out_pal;
    logic [CW-1:0]                r_out_count;

    logic                         in_ready, accept, out_load;
    logic                         is_full, is_empty, lo_below_hi, pair_diff;
    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_raddr_a, top_addr;
    logic [bsp_pkg::VALUE_W-1:0]  rdata_a, rdata_b;
    bsp_pkg::t_req_type           req;

    assign req         = bsp_pkg::t_req_type'(i_req.req_type);
    assign accept      = i_req.valid && in_ready;
    assign is_full     = (r_count == CW'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign top_addr    = AW'(r_count - 1'b1);
    assign lo_below_hi = (r_lo < r_hi);
    assign pair_diff   = (rdata_a != rdata_b);

    bsp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_req.push_value),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (r_hi),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsp_pkg::S_IDLE: begin
                if (accept) begin
                    if (req == bsp_pkg::REQ_CHECK && !is_empty) begin
                        n_state = bsp_pkg::S_CHK_RD;
                    end else begin
                        n_state = bsp_pkg::S_RESP;
                    end
                end
            end
            bsp_pkg::S_CHK_RD: begin
                n_state = lo_below_hi ? bsp_pkg::S_CHK_CMP : bsp_pkg::S_RESP;
            end
            bsp_pkg::S_CHK_CMP: begin
                n_state = pair_diff ? bsp_pkg::S_RESP : bsp_pkg::S_CHK_RD;
            end
            bsp_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = bsp_pkg::S_IDLE;
                end
            end
            default: n_state = bsp_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr_a = top_addr;
        out_load    = 1'b0;
        case (r_state)
            bsp_pkg::S_IDLE: begin
                in_ready = 1'b1;
                mem_we   = i_req.valid && req == bsp_pkg::REQ_PUSH && !is_full;
                mem_re   = i_req.valid && req == bsp_pkg::REQ_POP && !is_empty;
            end
            bsp_pkg::S_CHK_RD: begin
                mem_re      = lo_below_hi;
                mem_raddr_a = r_lo;
            end
            bsp_pkg::S_RESP: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsp_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (req == bsp_pkg::REQ_PUSH && !is_full) begin
                    r_count <= r_count + 1'b1;
                end
                if (req == bsp_pkg::REQ_POP && !is_empty) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_pal    <= 1'b0;
            r_res_pop    <= 1'b0;
            r_res_status <= bsp_pkg::ST_OK;
            r_lo         <= '0;
            r_hi         <= top_addr;
            case (req)
                bsp_pkg::REQ_PUSH: begin
                    if (is_full) begin
                        r_res_status <= bsp_pkg::ST_FULL;
                    end
                end
                bsp_pkg::REQ_POP: begin
                    if (is_empty) begin
                        r_res_status <= bsp_pkg::ST_EMPTY;
                    end else begin
                        r_res_pop <= 1'b1;
                    end
                end
                bsp_pkg::REQ_CHECK: begin
                    if (is_empty) begin
                        r_res_status <= bsp_pkg::ST_EMPTY;
                    end
                end
                default: ;
            endcase
        end
        // indices met with every pair equal: symmetric
        if (r_state == bsp_pkg::S_CHK_RD && !lo_below_hi) begin
            r_res_pal <= 1'b1;
        end
        if (r_state == bsp_pkg::S_CHK_CMP && !pair_diff) begin
            r_lo <= r_lo + 1'b1;
            r_hi <= r_hi - 1'b1;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_popped <= r_res_pop ? rdata_a : '0;
            r_out_pal    <= r_res_pal;
            r_out_count  <= r_count;
        end
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.popped_value  = r_out_popped;
    assign o_rsp.symmetric     = r_out_pal;
    assign o_rsp.entry_count   = bsp_pkg::COUNT_W'(r_out_count);
    assign o_rsp.is_full       = (r_out_count == CW'(DEPTH));
    assign o_rsp.is_empty      = (r_out_count == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept && req == bsp_pkg::REQ_PUSH && !is_full)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow the stack");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept && req == bsp_pkg::REQ_POP && !is_empty)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not shrink the stack");

    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsp_pkg::S_CHK_CMP |-> r_lo < r_hi)
        else $error("pair compare with crossed indices");

    a_pal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.symmetric) |-> o_rsp.status == bsp_pkg::ST_OK)
        else $error("palindrome flag on a refused item");
`endif

endmodule
